// File: sv/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, types and the CORDIC arctangent table of the polar
// vector adder.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int TABLE_LEN   = 24;
   localparam int PHASE_WIDTH = 32;
   localparam int GAIN_WIDTH  = 29;
   localparam int INDEX_WIDTH = 5;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int DEF_MAG_WIDTH     = 16;
   localparam int DEF_ANGLE_WIDTH   = 16;

   // 1/K^2 scaled by 2^30
   localparam logic [GAIN_WIDTH-1:0] INV_GAIN_SQ = 29'd395948877;

   localparam logic [PHASE_WIDTH-1:0] HALF_TURN   = 32'h8000_0000;
   localparam logic [PHASE_WIDTH-1:0] EIGHTH_TURN = 32'h2000_0000;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quad_type;

   function automatic logic [PHASE_WIDTH-1:0] atan_phase(input logic [INDEX_WIDTH-1:0] idx);
      logic [PHASE_WIDTH-1:0] val;
      unique case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051D;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2F9;
         5'd15:   val = 32'h0000_517C;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A2F;
         5'd19:   val = 32'h0000_0517;
         5'd20:   val = 32'h0000_028B;
         5'd21:   val = 32'h0000_0145;
         5'd22:   val = 32'h0000_00A2;
         5'd23:   val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: sv/pva_rot_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_rot_lane
// Pipelined CORDIC rotation, one micro-rotation per register stage. Turns a
// pre-rotated vector and residual phase into x and y components.
// ----------------------------------------------------------------------------
module pva_rot_lane
   import pva_pkg::*;
#(
   parameter int STAGES = DEF_CORDIC_STAGES,
   parameter int WIDTH  = DEF_MAG_WIDTH + FRAC_BITS + 4
) (
   input  logic                          clock,
   input  logic [STAGES-1:0]             stage_en,
   input  logic signed [WIDTH-1:0]       x_start,
   input  logic signed [WIDTH-1:0]       y_start,
   input  logic signed [PHASE_WIDTH-1:0] z_start,
   output logic signed [WIDTH-1:0]       x_out,
   output logic signed [WIDTH-1:0]       y_out
);

   logic signed [WIDTH-1:0]       x_ff [STAGES];
   logic signed [WIDTH-1:0]       y_ff [STAGES];
   logic signed [PHASE_WIDTH-1:0] z_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [WIDTH-1:0]       x_src, y_src, x_in, y_in;
      logic signed [PHASE_WIDTH-1:0] z_src, z_in;
      logic signed [PHASE_WIDTH-1:0] step;

      if (i == 0) begin : g_first
         assign x_src = x_start;
         assign y_src = y_start;
         assign z_src = z_start;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end

      assign step = signed'(atan_phase(INDEX_WIDTH'(i)));

      always_comb begin
         if (!z_src[PHASE_WIDTH-1]) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - step;
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + step;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign x_out = x_ff[STAGES-1];
   assign y_out = y_ff[STAGES-1];

endmodule

// File: sv/pva_vec_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_vec_pipe
// Pipelined CORDIC vectoring, one micro-rotation per register stage. Drives
// y to zero, accumulates the phase and carries the zero-length flag along.
// ----------------------------------------------------------------------------
module pva_vec_pipe
   import pva_pkg::*;
#(
   parameter int STAGES = DEF_CORDIC_STAGES,
   parameter int WIDTH  = DEF_MAG_WIDTH + FRAC_BITS + 4
) (
   input  logic                    clock,
   input  logic [STAGES-1:0]       stage_en,
   input  logic signed [WIDTH-1:0] x_start,
   input  logic signed [WIDTH-1:0] y_start,
   input  logic [PHASE_WIDTH-1:0]  acc_start,
   input  logic                    zero_start,
   output logic signed [WIDTH-1:0] x_out,
   output logic [PHASE_WIDTH-1:0]  acc_out,
   output logic                    zero_out
);

   logic signed [WIDTH-1:0]      x_ff    [STAGES];
   logic signed [WIDTH-1:0]      y_ff    [STAGES];
   logic [PHASE_WIDTH-1:0]       acc_ff  [STAGES];
   logic                         zero_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [WIDTH-1:0] x_src, y_src, x_in, y_in;
      logic [PHASE_WIDTH-1:0]  acc_src, acc_in;
      logic                    zero_src;

      if (i == 0) begin : g_first
         assign x_src    = x_start;
         assign y_src    = y_start;
         assign acc_src  = acc_start;
         assign zero_src = zero_start;
      end else begin : g_next
         assign x_src    = x_ff[i-1];
         assign y_src    = y_ff[i-1];
         assign acc_src  = acc_ff[i-1];
         assign zero_src = zero_ff[i-1];
      end

      always_comb begin
         if (!y_src[WIDTH-1] && (y_src != '0)) begin
            x_in   = x_src + (y_src >>> i);
            y_in   = y_src - (x_src >>> i);
            acc_in = acc_src + atan_phase(INDEX_WIDTH'(i));
         end else begin
            x_in   = x_src - (y_src >>> i);
            y_in   = y_src + (x_src >>> i);
            acc_in = acc_src - atan_phase(INDEX_WIDTH'(i));
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            acc_ff[i]  <= acc_in;
            zero_ff[i] <= zero_src;
         end
      end
   end

   assign x_out    = x_ff[STAGES-1];
   assign acc_out  = acc_ff[STAGES-1];
   assign zero_out = zero_ff[STAGES-1];

endmodule

// File: sv/polar_vector_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_vector_adder
// Adds two polar vectors: CORDIC rotation to x/y, component add, CORDIC
// vectoring back to magnitude and direction.
//
// Request channel (req_valid/req_ready) takes two magnitudes and two binary
// angles (2^ANGLE_WIDTH = 360 degrees). Response channel (rsp_valid/
// rsp_ready) gives the rounded magnitude of the sum and a signed direction
// (2^(ANGLE_WIDTH-1) = 180 degrees). A zero-length sum gives 0 and 0.
// Throughput: one transfer per cycle while rsp_ready stays high. There are
// 2*N + 6 register stages, N = min(CORDIC_STAGES, 24): the two N-stage
// CORDIC pipelines plus pre-rotation, add, sign fold, gain multiply,
// rounding and output register stages, the first loaded at the request
// transfer. Every stage has its own valid bit; a stage takes new data
// when it is empty or the stage after it moves, so bubbles collapse and
// requests keep flowing while a response waits until the pipeline is
// full. A stalled receiver holds the response register. Reset
// (synchronous) clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polar_vector_adder
   import pva_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
   parameter int MAG_WIDTH     = DEF_MAG_WIDTH,
   parameter int ANGLE_WIDTH   = DEF_ANGLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [MAG_WIDTH-1:0]          req_first_magnitude,
   input  logic [ANGLE_WIDTH-1:0]        req_first_direction,
   input  logic [MAG_WIDTH-1:0]          req_second_magnitude,
   input  logic [ANGLE_WIDTH-1:0]        req_second_direction,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [MAG_WIDTH:0]            rsp_sum_magnitude,
   output logic signed [ANGLE_WIDTH-1:0] rsp_sum_direction
);

   localparam int N        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
   localparam int W        = MAG_WIDTH + FRAC_BITS + 4;
   localparam int PW       = (W > 32) ? W : 33;
   localparam int HI_W     = PW - 32;
   localparam int LO_PW    = 32 + GAIN_WIDTH;
   localparam int HI_PW    = HI_W + GAIN_WIDTH;
   localparam int SW       = PW + 1;
   localparam int RW       = SW - FRAC_BITS;
   localparam int T        = 2 * N + 6;
   localparam int S_ROT    = 1;
   localparam int S_ADD    = N + 1;
   localparam int S_FOLD   = N + 2;
   localparam int S_VEC    = N + 3;
   localparam int S_MUL    = 2 * N + 3;
   localparam int S_RND    = 2 * N + 4;
   localparam int S_OUT    = 2 * N + 5;

   localparam logic [MAG_WIDTH:0] MAG_LIMIT = {{MAG_WIDTH{1'b1}}, 1'b0};
   localparam logic [PHASE_WIDTH-1:0] DIR_HALF_LSB = PHASE_WIDTH'(1) << (31 - ANGLE_WIDTH);

   typedef struct packed {
      logic signed [W-1:0]           x;
      logic signed [W-1:0]           y;
      logic signed [PHASE_WIDTH-1:0] z;
   } rot_start_type;

   function automatic rot_start_type polar_start(input logic [MAG_WIDTH-1:0] mag,
                                                 input logic [ANGLE_WIDTH-1:0] dir);
      logic [PHASE_WIDTH-1:0] phase;
      logic [PHASE_WIDTH-1:0] shifted;
      quad_type               quad;
      logic signed [W-1:0]    m;
      rot_start_type          s;
      phase   = {dir, {(PHASE_WIDTH - ANGLE_WIDTH){1'b0}}};
      shifted = phase + EIGHTH_TURN;
      quad    = quad_type'(shifted[PHASE_WIDTH-1 -: 2]);
      s.z     = signed'(phase - {shifted[PHASE_WIDTH-1 -: 2], {(PHASE_WIDTH - 2){1'b0}}});
      m       = signed'(W'(mag) << FRAC_BITS);
      unique case (quad)
         QUAD_EAST:  begin s.x = m;   s.y = '0;  end
         QUAD_NORTH: begin s.x = '0;  s.y = m;   end
         QUAD_WEST:  begin s.x = -m;  s.y = '0;  end
         QUAD_SOUTH: begin s.x = '0;  s.y = -m;  end
         default:    begin s.x = '0;  s.y = '0;  end
      endcase
      return s;
   endfunction

   // stage valid bits and advance enables
   logic [T-1:0] valid_ff;
   logic [T-1:0] valid_in;
   logic [T-1:0] en;

   assign valid_in  = {valid_ff[T-2:0], req_valid};
   assign en[T-1]   = !valid_ff[T-1] || rsp_ready;
   for (genvar k = 0; k < T - 1; k++) begin : g_en
      assign en[k] = !valid_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < T; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[T-1];

   // stage 0: quadrant pre-rotation
   rot_start_type start1_ff, start2_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         start1_ff <= polar_start(req_first_magnitude, req_first_direction);
         start2_ff <= polar_start(req_second_magnitude, req_second_direction);
      end
   end

   // rotation lanes
   logic signed [W-1:0] x1, y1, x2, y2;

   pva_rot_lane #(.STAGES(N), .WIDTH(W)) u_rot_first (
      .clock    (clock),
      .stage_en (en[S_ROT +: N]),
      .x_start  (start1_ff.x),
      .y_start  (start1_ff.y),
      .z_start  (start1_ff.z),
      .x_out    (x1),
      .y_out    (y1)
   );

   pva_rot_lane #(.STAGES(N), .WIDTH(W)) u_rot_second (
      .clock    (clock),
      .stage_en (en[S_ROT +: N]),
      .x_start  (start2_ff.x),
      .y_start  (start2_ff.y),
      .z_start  (start2_ff.z),
      .x_out    (x2),
      .y_out    (y2)
   );

   // component add
   logic signed [W-1:0] sum_x_ff, sum_y_ff;

   always_ff @(posedge clock) begin
      if (en[S_ADD]) begin
         sum_x_ff <= x1 + x2;
         sum_y_ff <= y1 + y2;
      end
   end

   // fold into right half plane, flag zero-length sum
   logic signed [W-1:0]    fold_x_ff, fold_y_ff;
   logic [PHASE_WIDTH-1:0] fold_acc_ff;
   logic                   fold_zero_ff;

   always_ff @(posedge clock) begin
      if (en[S_FOLD]) begin
         fold_zero_ff <= (sum_x_ff == '0) && (sum_y_ff == '0);
         if (sum_x_ff[W-1]) begin
            fold_x_ff   <= -sum_x_ff;
            fold_y_ff   <= -sum_y_ff;
            fold_acc_ff <= HALF_TURN;
         end else begin
            fold_x_ff   <= sum_x_ff;
            fold_y_ff   <= sum_y_ff;
            fold_acc_ff <= '0;
         end
      end
   end

   // vectoring
   logic signed [W-1:0]    vec_x;
   logic [PHASE_WIDTH-1:0] vec_acc;
   logic                   vec_zero;

   pva_vec_pipe #(.STAGES(N), .WIDTH(W)) u_vec (
      .clock      (clock),
      .stage_en   (en[S_VEC +: N]),
      .x_start    (fold_x_ff),
      .y_start    (fold_y_ff),
      .acc_start  (fold_acc_ff),
      .zero_start (fold_zero_ff),
      .x_out      (vec_x),
      .acc_out    (vec_acc),
      .zero_out   (vec_zero)
   );

   // gain correction, split into two partial products
   logic [PW-1:0]          ux;
   logic [PHASE_WIDTH-1:0] acc_rnd;
   logic [LO_PW-1:0]       lo_prod_ff;
   logic [HI_PW-1:0]       hi_prod_ff;
   logic [ANGLE_WIDTH-1:0] mul_dir_ff;
   logic                   mul_zero_ff;

   assign ux      = vec_x[W-1] ? '0 : PW'($unsigned(vec_x));
   assign acc_rnd = vec_acc + DIR_HALF_LSB;

   always_ff @(posedge clock) begin
      if (en[S_MUL]) begin
         lo_prod_ff  <= LO_PW'(ux[31:0]) * LO_PW'(INV_GAIN_SQ);
         hi_prod_ff  <= HI_PW'(ux[PW-1:32]) * HI_PW'(INV_GAIN_SQ);
         mul_dir_ff  <= acc_rnd[PHASE_WIDTH-1 -: ANGLE_WIDTH];
         mul_zero_ff <= vec_zero;
      end
   end

   // sum partial products, round off fraction
   logic [SW-1:0]          scaled;
   logic [SW-1:0]          rounded;
   logic [RW-1:0]          rnd_mag_ff;
   logic [ANGLE_WIDTH-1:0] rnd_dir_ff;
   logic                   rnd_zero_ff;

   assign scaled  = (SW'(hi_prod_ff) << 2) + SW'(lo_prod_ff >> 30);
   assign rounded = scaled + (SW'(1) << (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (en[S_RND]) begin
         rnd_mag_ff  <= rounded[SW-1:FRAC_BITS];
         rnd_dir_ff  <= mul_dir_ff;
         rnd_zero_ff <= mul_zero_ff;
      end
   end

   // saturate, response register
   logic [MAG_WIDTH:0]     out_mag_ff;
   logic [ANGLE_WIDTH-1:0] out_dir_ff;

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         if (rnd_zero_ff) begin
            out_mag_ff <= '0;
            out_dir_ff <= '0;
         end else begin
            out_mag_ff <= (rnd_mag_ff > RW'(MAG_LIMIT)) ? MAG_LIMIT : rnd_mag_ff[MAG_WIDTH:0];
            out_dir_ff <= rnd_dir_ff;
         end
      end
   end

   assign rsp_sum_magnitude = out_mag_ff;
   assign rsp_sum_direction = signed'(out_dir_ff);

   // assertions
   a_mag_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sum_magnitude <= MAG_LIMIT))
      else $error("sum magnitude above saturation limit");

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&valid_ff) && !rsp_ready))
      else $error("request stalled while pipeline has room");

   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[S_RND] && en[S_OUT] && rnd_zero_ff) |=>
         ((rsp_sum_magnitude == '0) && (rsp_sum_direction == '0)))
      else $error("zero-length sum not reported as zero");

endmodule
